// File: sv/lcs_pkg.sv
package lcs_pkg;

    localparam int MAX_LEN_DEF     = 64;
    localparam int SYMBOL_BITS_DEF = 8;

    localparam logic [1:0] FUNC_LOAD_A   = 2'd0;
    localparam logic [1:0] FUNC_LOAD_B   = 2'd1;
    localparam logic [1:0] FUNC_COMPUTE  = 2'd2;
    localparam logic [1:0] FUNC_UNUSED   = 2'd3;

    // Traceback bits stored per table cell.
    localparam int BIT_EQ   = 0;
    localparam int BIT_LEFT = 1;

endpackage

// File: sv/lcs_cell.sv
module lcs_cell #(
    parameter int SYM_W = 8,
    parameter int SCORE_W = 7,
    parameter int IDX_W = 6,
    parameter int DEPTH = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               clear,
    input  logic               load_en,
    input  logic [SYM_W-1:0]   load_sym,
    input  logic               in_v,
    input  logic [IDX_W-1:0]   in_row,
    input  logic [SYM_W-1:0]   in_sym,
    input  logic [SCORE_W-1:0] in_score,
    input  logic [SCORE_W-1:0] in_diag,
    output logic               out_v,
    output logic [IDX_W-1:0]   out_row,
    output logic [SYM_W-1:0]   out_sym,
    output logic [SCORE_W-1:0] out_score,
    output logic [SCORE_W-1:0] out_diag,
    input  logic [IDX_W-1:0]   rd_addr,
    output logic [1:0]         rd_bits
);
    import lcs_pkg::*;

    logic [SYM_W-1:0]   b_reg;
    logic [SCORE_W-1:0] score_reg;
    logic [SCORE_W-1:0] prev_reg;
    logic               v_reg;
    logic [IDX_W-1:0]   row_reg;
    logic [SYM_W-1:0]   sym_reg;
    logic [1:0]         bits_mem [DEPTH];
    logic [1:0]         rd_reg;
    logic               eq;
    logic [SCORE_W-1:0] score_next;
    logic [1:0]         wbits;

    always_comb
    begin
        eq = (in_sym == b_reg);
        if (eq)
        begin
            score_next = in_diag + SCORE_W'(1);
        end
        else
        begin
            score_next = (score_reg > in_score) ? score_reg : in_score;
        end
        wbits = '0;
        wbits[BIT_EQ] = eq;
        wbits[BIT_LEFT] = (score_next == in_score);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else
        begin
            v_reg <= in_v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            b_reg <= load_sym;
        end
        if (clear)
        begin
            score_reg <= '0;
            prev_reg  <= '0;
        end
        else if (in_v)
        begin
            score_reg <= score_next;
            prev_reg  <= score_reg;
            bits_mem[in_row] <= wbits;
        end
        row_reg <= in_row;
        sym_reg <= in_sym;
        rd_reg  <= bits_mem[rd_addr];
    end

    assign out_v     = v_reg;
    assign out_row   = row_reg;
    assign out_sym   = sym_reg;
    assign out_score = score_reg;
    assign out_diag  = prev_reg;
    assign rd_bits   = rd_reg;

endmodule

// File: sv/lcs_length_and_traceback.sv
// Longest common subsequence engine.
// Requests arrive on start/func/symbol and are taken at a clock edge where
// start is high and busy is low. A load request (func 0 or 1) appends one
// symbol to the first or second string; symbols beyond
// MAX_LEN are dropped and remembered in the overflow flag.
// A compute request (func 2) runs a wavefront through a row of MAX_LEN cells,
// one cell per column of the score table. Rows of the first string enter the
// first cell one per cycle and ripple right through the cell chain.
// Each cell keeps two traceback bits per row in a small local memory.
// The traceback then runs at most first_length + second_length steps, each
// a registered memory read and then a decision; each result is emitted after
// a registered read from the answer buffer.
// Results appear with out_valid high for exactly one cycle each, in forward
// order; the receiver cannot stall them. An empty subsequence gives a single
// result with has_symbol low. Reset empties both strings and the flag; the
// string and table memories need no clearing. Unused func codes are ignored.
module lcs_length_and_traceback #(
    parameter int MAX_LEN = lcs_pkg::MAX_LEN_DEF,
    parameter int SYMBOL_BITS = lcs_pkg::SYMBOL_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] func,
    input  logic [7:0] symbol,
    output logic       out_valid,
    output logic [7:0] lcs_symbol,
    output logic [5:0] position,
    output logic [6:0] lcs_length,
    output logic       has_symbol,
    output logic       overflowed,
    output logic       last
);
    import lcs_pkg::*;

    localparam int SYM_W   = (SYMBOL_BITS < 8) ? SYMBOL_BITS : 8;
    localparam int IDX_W   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int LEN_W   = $clog2(MAX_LEN + 1);
    localparam int CNT_W   = $clog2(2 * MAX_LEN + 3);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_FILL  = 6'b000010,
        S_TB_RD = 6'b000100,
        S_TB_EV = 6'b001000,
        S_EM_RD = 6'b010000,
        S_EM_OUT = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [LEN_W-1:0] la_reg, la_next, lb_reg, lb_next;
    logic             drop_reg, drop_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [LEN_W-1:0] ti_reg, ti_next, tj_reg, tj_next;
    logic [LEN_W-1:0] idx_reg, idx_next, total_reg, total_next, k_reg, k_next;
    logic             feed_v_reg;
    logic [IDX_W-1:0] feed_row_reg;

    logic [SYM_W-1:0] a_mem [MAX_LEN];
    logic [SYM_W-1:0] ans_mem [MAX_LEN];
    logic [SYM_W-1:0] a_rd_reg, ans_rd_reg;
    logic [IDX_W-1:0] a_addr, row_addr, ans_addr;
    logic             ans_we;
    logic [IDX_W-1:0] ans_waddr;

    logic             ov_reg, ov_next;
    logic [7:0]       osym_reg, osym_next;
    logic [5:0]       opos_reg, opos_next;
    logic [6:0]       olen_reg, olen_next;
    logic             ohas_reg, ohas_next, olast_reg, olast_next, oovf_reg, oovf_next;

    logic             accept, clear_cells;
    logic [SYM_W-1:0] sym_in;

    // Cell chain links; element j feeds cell j.
    logic               lv   [MAX_LEN+1];
    logic [IDX_W-1:0]   lrow [MAX_LEN+1];
    logic [SYM_W-1:0]   lsym [MAX_LEN+1];
    logic [LEN_W-1:0]   lsc  [MAX_LEN+1];
    logic [LEN_W-1:0]   ldg  [MAX_LEN+1];
    logic [1:0]         cbits [MAX_LEN];

    logic [IDX_W-1:0]   lb_slot;
    logic [IDX_W-1:0]   tj_m1;
    logic [1:0]         sel_bits;

    assign accept = start && !busy;
    assign sym_in = symbol[SYM_W-1:0];
    assign lb_slot = lb_reg[IDX_W-1:0];
    assign tj_m1 = IDX_W'(tj_reg - LEN_W'(1));
    assign sel_bits = cbits[tj_m1];

    assign lv[0]   = feed_v_reg;
    assign lrow[0] = feed_row_reg;
    assign lsym[0] = a_rd_reg;
    assign lsc[0]  = '0;
    assign ldg[0]  = '0;

    genvar g;
    generate
        for (g = 0; g < MAX_LEN; g++)
        begin : g_cell
            lcs_cell #(
                .SYM_W(SYM_W), .SCORE_W(LEN_W), .IDX_W(IDX_W), .DEPTH(MAX_LEN)
            ) u_cell (
                .clk(clk), .rst_n(rst_n),
                .clear(clear_cells),
                .load_en(accept && func == FUNC_LOAD_B && lb_reg < LEN_W'(MAX_LEN)
                         && lb_slot == IDX_W'(g)),
                .load_sym(sym_in),
                .in_v(lv[g]), .in_row(lrow[g]), .in_sym(lsym[g]),
                .in_score(lsc[g]), .in_diag(ldg[g]),
                .out_v(lv[g+1]), .out_row(lrow[g+1]), .out_sym(lsym[g+1]),
                .out_score(lsc[g+1]), .out_diag(ldg[g+1]),
                .rd_addr(row_addr), .rd_bits(cbits[g])
            );
        end
    endgenerate

    // Row address for traceback reads and first-string reads.
    assign row_addr = IDX_W'(ti_reg - LEN_W'(1));
    assign a_addr = (state_reg == S_FILL) ? cnt_reg[IDX_W-1:0] : row_addr;
    assign ans_addr = k_reg[IDX_W-1:0];
    assign ans_waddr = IDX_W'(idx_reg - LEN_W'(1));

    always_ff @(posedge clk)
    begin
        if (accept && func == FUNC_LOAD_A && la_reg < LEN_W'(MAX_LEN))
        begin
            a_mem[la_reg[IDX_W-1:0]] <= sym_in;
        end
        a_rd_reg <= a_mem[a_addr];
        if (ans_we)
        begin
            ans_mem[ans_waddr] <= a_rd_reg;
        end
        ans_rd_reg <= ans_mem[ans_addr];
        feed_row_reg <= cnt_reg[IDX_W-1:0];
        osym_reg <= osym_next;
        opos_reg <= opos_next;
        olen_reg <= olen_next;
        ohas_reg <= ohas_next;
        olast_reg <= olast_next;
        oovf_reg <= oovf_next;
    end

    always_comb
    begin
        state_next = state_reg;
        la_next = la_reg;
        lb_next = lb_reg;
        drop_next = drop_reg;
        cnt_next = cnt_reg;
        ti_next = ti_reg;
        tj_next = tj_reg;
        idx_next = idx_reg;
        total_next = total_reg;
        k_next = k_reg;
        clear_cells = 1'b0;
        ans_we = 1'b0;
        ov_next = 1'b0;
        osym_next = osym_reg;
        opos_next = opos_reg;
        olen_next = olen_reg;
        ohas_next = ohas_reg;
        olast_next = olast_reg;
        oovf_next = oovf_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (func)
                        FUNC_LOAD_A:
                        begin
                            if (la_reg < LEN_W'(MAX_LEN))
                            begin
                                la_next = la_reg + LEN_W'(1);
                            end
                            else
                            begin
                                drop_next = 1'b1;
                            end
                        end
                        FUNC_LOAD_B:
                        begin
                            if (lb_reg < LEN_W'(MAX_LEN))
                            begin
                                lb_next = lb_reg + LEN_W'(1);
                            end
                            else
                            begin
                                drop_next = 1'b1;
                            end
                        end
                        FUNC_COMPUTE:
                        begin
                            clear_cells = 1'b1;
                            cnt_next = '0;
                            state_next = S_FILL;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_FILL:
            begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(la_reg) + CNT_W'(MAX_LEN + 1))
                begin
                    if (la_reg == '0 || lb_reg == '0)
                    begin
                        total_next = '0;
                    end
                    else
                    begin
                        total_next = lsc[IDX_W'(lb_reg - LEN_W'(1)) + 1];
                    end
                    ti_next = la_reg;
                    tj_next = lb_reg;
                    idx_next = total_next;
                    k_next = '0;
                    if (la_reg == '0 || lb_reg == '0)
                    begin
                        state_next = S_EM_RD;
                    end
                    else
                    begin
                        state_next = S_TB_RD;
                    end
                end
            end
            S_TB_RD:
            begin
                state_next = S_TB_EV;
            end
            S_TB_EV:
            begin
                if (sel_bits[BIT_EQ])
                begin
                    if (idx_reg != '0)
                    begin
                        ans_we = 1'b1;
                        idx_next = idx_reg - LEN_W'(1);
                    end
                    ti_next = ti_reg - LEN_W'(1);
                    tj_next = tj_reg - LEN_W'(1);
                end
                else if (sel_bits[BIT_LEFT])
                begin
                    tj_next = tj_reg - LEN_W'(1);
                end
                else
                begin
                    ti_next = ti_reg - LEN_W'(1);
                end
                if (ti_next == '0 || tj_next == '0)
                begin
                    state_next = S_EM_RD;
                end
                else
                begin
                    state_next = S_TB_RD;
                end
            end
            S_EM_RD:
            begin
                state_next = S_EM_OUT;
            end
            S_EM_OUT:
            begin
                ov_next = 1'b1;
                oovf_next = drop_reg;
                olen_next = 7'(total_reg);
                opos_next = 6'(k_reg);
                if (total_reg == '0)
                begin
                    osym_next = '0;
                    ohas_next = 1'b0;
                    olast_next = 1'b1;
                end
                else
                begin
                    osym_next = 8'(ans_rd_reg);
                    ohas_next = 1'b1;
                    olast_next = (k_reg + LEN_W'(1) == total_reg);
                end
                k_next = k_reg + LEN_W'(1);
                if (olast_next)
                begin
                    la_next = '0;
                    lb_next = '0;
                    drop_next = 1'b0;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_EM_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            la_reg <= '0;
            lb_reg <= '0;
            drop_reg <= 1'b0;
            cnt_reg <= '0;
            ti_reg <= '0;
            tj_reg <= '0;
            idx_reg <= '0;
            total_reg <= '0;
            k_reg <= '0;
            feed_v_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            la_reg <= la_next;
            lb_reg <= lb_next;
            drop_reg <= drop_next;
            cnt_reg <= cnt_next;
            ti_reg <= ti_next;
            tj_reg <= tj_next;
            idx_reg <= idx_next;
            total_reg <= total_next;
            k_reg <= k_next;
            feed_v_reg <= (state_reg == S_FILL) && (CNT_W'(la_reg) > cnt_reg);
            ov_reg <= ov_next;
        end
    end

    assign busy       = (state_reg != S_IDLE);
    assign out_valid  = ov_reg;
    assign lcs_symbol = osym_reg;
    assign position   = opos_reg;
    assign lcs_length = olen_reg;
    assign has_symbol = ohas_reg;
    assign overflowed = oovf_reg;
    assign last       = olast_reg;

endmodule
